### rtl/mer_pkg.sv
// Shared types, widths and a helper function for the midpoint ellipse raster unit.
// Depends on nothing; imported by mer_mult and midpoint_ellipse_raster_unit.
package mer_pkg;

    localparam int COORD_W = 16;
    localparam int RAD_W   = 11;
    localparam int PIX_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * RAD_W;
    localparam int SLOPE_W = 35;
    localparam int DEC_W   = 40;
    localparam int MUL_W   = 2 * RAD_W + 2;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = PROD_W + 2;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RX,
        ST_MUL_RY,
        ST_MUL_SY,
        ST_INIT,
        ST_R2_HX,
        ST_R2_A,
        ST_R2_YM,
        ST_R2_B,
        ST_R2_RR,
        ST_R2_C,
        ST_ROUND,
        ST_STEP_A,
        ST_STEP_B,
        ST_EMIT
    } t_state;

    // A quarter-unit value plus one half, truncated toward zero.
    function automatic logic signed [DEC_W-1:0] round_quarters(
        input logic signed [ACC_W-1:0] q
    );
        logic signed [ACC_W-1:0] v;
        v = q + ACC_W'(2);
        if (v[ACC_W-1]) begin
            v = v + ACC_W'(3);
        end
        v = v >>> 2;
        return v[DEC_W-1:0];
    endfunction

endpackage

### rtl/mer_mult.sv
// Shared unsigned multiplier with a registered product.
// Depends on mer_pkg for the operand and product widths.
module mer_mult
    import mer_pkg::*;
(
    input  logic              i_clk,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

### rtl/midpoint_ellipse_raster_unit.sv
// Top level of the midpoint ellipse raster unit: sequencer, state and pixel output.
// Depends on mer_pkg and on mer_mult for all multiplications.
//
// The unit takes one item at a time and is not ready until every pixel of that
// item has been taken. A start item squares both radii and forms the initial slope
// on the shared multiplier, sets up the state, rounds the decision value and then
// emits four pixels. A step item updates the position, then the decision value, and
// emits four pixels, one pixel per cycle through the single result port while the
// receiver is ready. The one step that enters region two first runs that region's
// set-up on the shared multiplier. A step that emits nothing returns to idle.
module midpoint_ellipse_raster_unit
    import mer_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic                      i_mode,
    input  logic signed [COORD_W-1:0] i_center_x,
    input  logic signed [COORD_W-1:0] i_center_y,
    input  logic        [RAD_W-1:0]   i_radius_x,
    input  logic        [RAD_W-1:0]   i_radius_y,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic signed [PIX_W-1:0]   o_pixel_x,
    output logic signed [PIX_W-1:0]   o_pixel_y,
    output logic                      o_last_of_point,
    output logic                      o_more_points
);

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_ctr_x, r_ctr_y;
    logic [RAD_W-1:0]          r_rad_x, r_rad_y;
    logic [SQ_W-1:0]           r_rx_sq, r_ry_sq;
    logic [RAD_W-1:0]          r_cur_x, r_cur_y;
    logic [SLOPE_W-1:0]        r_sx, r_sy;
    logic signed [DEC_W-1:0]   r_dec;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_in_r2;
    logic                      r_running;
    logic                      r_flag;
    logic [1:0]                r_k;

    logic [MUL_W-1:0]  w_mul_a, w_mul_b;
    logic [PROD_W-1:0] w_prod;
    logic              w_in_acc, w_out_acc;
    logic              w_dec_pos;
    logic [RAD_W:0]    w_hx;
    logic [RAD_W-1:0]  w_ym;
    logic [SLOPE_W-1:0] w_two_ry_sq, w_two_rx_sq;

    mer_mult u_mult (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    assign w_in_acc    = i_valid && o_ready;
    assign w_out_acc   = o_valid && i_ready;
    assign w_dec_pos   = !r_dec[DEC_W-1] && (r_dec != '0);
    assign w_hx        = {r_cur_x, 1'b1};
    assign w_ym        = (r_cur_y == '0) ? RAD_W'(1) : r_cur_y - RAD_W'(1);
    assign w_two_ry_sq = SLOPE_W'({r_ry_sq, 1'b0});
    assign w_two_rx_sq = SLOPE_W'({r_rx_sq, 1'b0});

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_mode == MODE_START) begin
                        n_state = ST_MUL_RX;
                    end else if (r_running && !r_in_r2 && !(r_sx < r_sy)) begin
                        n_state = ST_R2_HX;
                    end else if (r_running) begin
                        n_state = ST_STEP_A;
                    end
                end
            end
            ST_MUL_RX: n_state = ST_MUL_RY;
            ST_MUL_RY: n_state = ST_MUL_SY;
            ST_MUL_SY: n_state = ST_INIT;
            ST_INIT:   n_state = ST_ROUND;
            ST_R2_HX:  n_state = ST_R2_A;
            ST_R2_A:   n_state = ST_R2_YM;
            ST_R2_YM:  n_state = ST_R2_B;
            ST_R2_B:   n_state = ST_R2_RR;
            ST_R2_RR:  n_state = ST_R2_C;
            ST_R2_C:   n_state = ST_ROUND;
            ST_ROUND:  n_state = r_in_r2 ? ST_STEP_A : ST_EMIT;
            ST_STEP_A: n_state = (r_in_r2 && r_cur_y == '0) ? ST_IDLE : ST_STEP_B;
            ST_STEP_B: n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_acc && r_k == 2'd3) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_EMIT);
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_MUL_RX: begin
                w_mul_a = MUL_W'(r_rad_x);
                w_mul_b = MUL_W'(r_rad_x);
            end
            ST_MUL_RY: begin
                w_mul_a = MUL_W'(r_rad_y);
                w_mul_b = MUL_W'(r_rad_y);
            end
            ST_MUL_SY: begin
                w_mul_a = MUL_W'(r_rx_sq);
                w_mul_b = MUL_W'(r_rad_y);
            end
            ST_R2_HX: begin
                w_mul_a = MUL_W'(w_hx);
                w_mul_b = MUL_W'(w_hx);
            end
            ST_R2_A: begin
                w_mul_a = MUL_W'(r_ry_sq);
                w_mul_b = w_prod[MUL_W-1:0];
            end
            ST_R2_YM: begin
                w_mul_a = MUL_W'(w_ym);
                w_mul_b = MUL_W'(w_ym);
            end
            ST_R2_B: begin
                w_mul_a = MUL_W'(r_rx_sq);
                w_mul_b = w_prod[MUL_W-1:0];
            end
            ST_R2_RR: begin
                w_mul_a = MUL_W'(r_rx_sq);
                w_mul_b = MUL_W'(r_ry_sq);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_running <= 1'b0;
            r_in_r2   <= 1'b0;
            r_k       <= '0;
            r_ctr_x   <= '0;
            r_ctr_y   <= '0;
            r_rx_sq   <= '0;
            r_ry_sq   <= '0;
            r_cur_x   <= '0;
            r_cur_y   <= '0;
            r_sx      <= '0;
            r_sy      <= '0;
            r_dec     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_k <= '0;
                    if (w_in_acc && i_mode == MODE_START) begin
                        r_ctr_x <= i_center_x;
                        r_ctr_y <= i_center_y;
                        r_rad_x <= i_radius_x;
                        r_rad_y <= i_radius_y;
                    end
                end
                ST_MUL_RY: r_rx_sq <= w_prod[SQ_W-1:0];
                ST_MUL_SY: r_ry_sq <= w_prod[SQ_W-1:0];
                ST_INIT: begin
                    r_sy    <= SLOPE_W'({w_prod, 1'b0});
                    r_sx    <= '0;
                    r_cur_x <= '0;
                    r_cur_y <= r_rad_y;
                    r_in_r2 <= 1'b0;
                    r_acc   <= (ACC_W'(r_ry_sq) << 2) + ACC_W'(r_rx_sq)
                             - (ACC_W'(w_prod) << 2);
                end
                ST_R2_YM: r_acc <= ACC_W'(w_prod);
                ST_R2_RR: r_acc <= r_acc + (ACC_W'(w_prod) << 2);
                ST_R2_C: begin
                    r_acc   <= r_acc - (ACC_W'(w_prod) << 2);
                    r_in_r2 <= 1'b1;
                end
                ST_ROUND: r_dec <= round_quarters(r_acc);
                ST_STEP_A: begin
                    if (!r_in_r2) begin
                        r_cur_x <= r_cur_x + RAD_W'(1);
                        r_sx    <= r_sx + w_two_ry_sq;
                        r_flag  <= !r_dec[DEC_W-1];
                        if (!r_dec[DEC_W-1]) begin
                            r_cur_y <= r_cur_y - RAD_W'(1);
                            r_sy    <= r_sy - w_two_rx_sq;
                        end
                    end else if (r_cur_y == '0) begin
                        r_running <= 1'b0;
                    end else begin
                        r_cur_y <= r_cur_y - RAD_W'(1);
                        r_sy    <= r_sy - w_two_rx_sq;
                        r_flag  <= !w_dec_pos;
                        if (!w_dec_pos) begin
                            r_cur_x <= r_cur_x + RAD_W'(1);
                            r_sx    <= r_sx + w_two_ry_sq;
                        end
                    end
                end
                ST_STEP_B: begin
                    if (!r_in_r2) begin
                        r_dec <= r_dec + DEC_W'(r_ry_sq) + DEC_W'(r_sx)
                               - (r_flag ? DEC_W'(r_sy) : DEC_W'(0));
                    end else begin
                        r_dec <= r_dec + DEC_W'(r_rx_sq) - DEC_W'(r_sy)
                               + (r_flag ? DEC_W'(r_sx) : DEC_W'(0));
                    end
                end
                ST_EMIT: begin
                    if (w_out_acc) begin
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_running <= (r_cur_y != '0);
                        end
                    end
                end
                default: begin
                    r_k <= r_k;
                end
            endcase
        end
    end

    always_comb begin
        if (r_k[0]) begin
            o_pixel_x = PIX_W'(r_ctr_x) - $signed(PIX_W'(r_cur_x));
        end else begin
            o_pixel_x = PIX_W'(r_ctr_x) + $signed(PIX_W'(r_cur_x));
        end
        if (r_k[1]) begin
            o_pixel_y = PIX_W'(r_ctr_y) - $signed(PIX_W'(r_cur_y));
        end else begin
            o_pixel_y = PIX_W'(r_ctr_y) + $signed(PIX_W'(r_cur_y));
        end
        o_last_of_point = (r_k == 2'd3);
        o_more_points   = (r_cur_y != '0);
    end

endmodule
